FILE: design/refraction_direction_unit_macros.svh
// Assertion macros for the refraction direction unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef REFRACTION_DIRECTION_UNIT_MACROS_SVH
`define REFRACTION_DIRECTION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDU_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rdu_pkg.sv
// Package of the refraction direction unit: register codes, constants and the
// per-request context carried down the pipeline. No dependencies.
`default_nettype none

package rdu_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgRefrIndex  = 1'b0,
    CfgTransCoeff = 1'b1
  } cfg_reg_e;

  localparam logic [13:0] RefrIndexRst  = 14'd4096;
  localparam logic [15:0] TransCoeffRst = 16'd0;
  localparam logic [13:0] EtaOne        = 14'd4096;
  localparam logic [28:0] OneQ28        = 29'h1000_0000;
  localparam logic [23:0] WeightMax     = 24'hFF_FFFF;

  // Iteration counts of the bit-serial units, one bit per stage.
  localparam int unsigned DivTSteps   = 29;
  localparam int unsigned SqrtSteps   = 29;
  localparam int unsigned DivDirSteps = 17;
  localparam int unsigned DivWtSteps  = 24;

  // Total register stages from input to output register.
  localparam int unsigned PipeDepth = 18 + DivTSteps + SqrtSteps + DivDirSteps + DivWtSteps;

  // Per-request context that travels alongside the arithmetic.
  typedef struct packed {
    logic [2:0][15:0] n0;
    logic [2:0][15:0] v;
    logic             flip;
    logic [28:0]      cmag;
    logic [13:0]      a;
    logic [13:0]      b;
    logic [27:0]      a2;
    logic [27:0]      b2;
    logic             tir;
    logic [2:0][15:0] w;
  } rdu_ctx_t;

endpackage

`default_nettype wire

FILE: design/refraction_direction_unit.sv
// Refraction direction unit: pipelined Snell refraction with total internal
// reflection detection. Depends on rdu_pkg and refraction_direction_unit_macros.svh.
//
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   normal_{x,y,z}_i, view_{x,y,z}_i
// out      out_valid_o / out_stall_i refr_{x,y,z}_o, total_reflect_o, weight_o
// cfg      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One request is taken every cycle unless a held result stalls the pipeline; it passes
// 117 register stages, from the input capture to the output register.
// Most of the stages belong to the root-argument divider, the square root, the
// direction divider and the weight divider, each resolving one bit per stage.
// Reset clears all stage valid bits and sets eta to 1.0 and kt to 0.
// A held result stalls the whole pipeline; in_stall_o is high only then.
`default_nettype none

`include "refraction_direction_unit_macros.svh"

module refraction_direction_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // request
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  // result
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] refr_x_o,
  output logic signed [15:0] refr_y_o,
  output logic signed [15:0] refr_z_o,
  output logic               total_reflect_o,
  output logic [23:0]        weight_o
);

  localparam int unsigned Depth = rdu_pkg::PipeDepth;
  localparam int unsigned NA    = rdu_pkg::DivTSteps;
  localparam int unsigned NS    = rdu_pkg::SqrtSteps;
  localparam int unsigned NB    = rdu_pkg::DivDirSteps;
  localparam int unsigned NC    = rdu_pkg::DivWtSteps;

  // Configuration registers.
  logic [13:0] refr_index_q;
  logic [15:0] trans_coeff_q;
  logic [13:0] eta_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refr_index_q  <= rdu_pkg::RefrIndexRst;
      trans_coeff_q <= rdu_pkg::TransCoeffRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdu_pkg::CfgRefrIndex:  refr_index_q  <= cfg_data_i[13:0];
        rdu_pkg::CfgTransCoeff: trans_coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero index is treated as the smallest step.
  assign eta_e = (refr_index_q == '0) ? 14'd1 : refr_index_q;

  // Valid bits and global advance.
  logic [Depth-1:0] vld_q;
  logic             pipe_adv;

  assign pipe_adv    = ~vld_q[Depth-1] | ~out_stall_i;
  assign in_stall_o  = ~pipe_adv;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Stage 1: capture and form the n.v products.
  rdu_pkg::rdu_ctx_t s1_ctx_q, s1_ctx;
  logic signed [31:0] s1_prod_q [3];

  always_comb begin
    s1_ctx    = '0;
    s1_ctx.n0 = {normal_z_i, normal_y_i, normal_x_i};
    s1_ctx.v  = {view_z_i, view_y_i, view_x_i};
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s1_ctx_q      <= s1_ctx;
      s1_prod_q[0]  <= normal_x_i * view_x_i;
      s1_prod_q[1]  <= normal_y_i * view_y_i;
      s1_prod_q[2]  <= normal_z_i * view_z_i;
    end
  end

  // Stage 2: cosine, side of the surface, saturated magnitude.
  rdu_pkg::rdu_ctx_t s2_ctx_q, s2_ctx;
  logic signed [33:0] s2_dot;
  logic [33:0]        s2_dmag;

  always_comb begin
    s2_dot  = 34'(s1_prod_q[0]) + 34'(s1_prod_q[1]) + 34'(s1_prod_q[2]);
    s2_dmag = s2_dot[33] ? 34'(-s2_dot) : 34'(s2_dot);
    s2_ctx      = s1_ctx_q;
    s2_ctx.flip = s2_dot[33];
    s2_ctx.cmag = (s2_dmag > 34'(rdu_pkg::OneQ28)) ? rdu_pkg::OneQ28 : s2_dmag[28:0];
    s2_ctx.a    = s2_dot[33] ? eta_e : rdu_pkg::EtaOne;
    s2_ctx.b    = s2_dot[33] ? rdu_pkg::EtaOne : eta_e;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) s2_ctx_q <= s2_ctx;
  end

  // Stage 3: cosine squared and the squared index terms.
  rdu_pkg::rdu_ctx_t s3_ctx_q, s3_ctx;
  logic [57:0]       s3_csq_q;

  always_comb begin
    s3_ctx    = s2_ctx_q;
    s3_ctx.a2 = 28'(s2_ctx_q.a) * 28'(s2_ctx_q.a);
    s3_ctx.b2 = 28'(s2_ctx_q.b) * 28'(s2_ctx_q.b);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s3_ctx_q <= s3_ctx;
      s3_csq_q <= 58'(s2_ctx_q.cmag) * 58'(s2_ctx_q.cmag);
    end
  end

  // Stage 4: sine squared, scaled down to 33 bits.
  rdu_pkg::rdu_ctx_t s4_ctx_q;
  logic [32:0]       s4_s24_q;
  logic [57:0]       s4_diff;

  assign s4_diff = (58'd1 << 56) - s3_csq_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s4_ctx_q <= s3_ctx_q;
      s4_s24_q <= s4_diff[56:24];
    end
  end

  // Stage 5: low partial product of sine squared times a^2.
  rdu_pkg::rdu_ctx_t s5_ctx_q;
  logic [59:0]       s5_nlo_q;
  logic              s5_nhi_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s5_ctx_q <= s4_ctx_q;
      s5_nlo_q <= 60'(s4_s24_q[31:0]) * 60'(s4_ctx_q.a2);
      s5_nhi_q <= s4_s24_q[32];
    end
  end

  // Stage 6: full dividend and divider setup for (1-c^2)/eta^2.
  rdu_pkg::rdu_ctx_t da_ctx_q [NA+1];
  logic [31:0]       da_rem_q [NA+1];
  logic [28:0]       da_nlo_q [NA+1];
  logic [28:0]       da_q_q   [NA+1];
  logic              da_ovf_q [NA+1];
  logic [60:0]       s6_num;
  logic [31:0]       s6_den;

  always_comb begin
    s6_num = 61'(s5_nlo_q) + (s5_nhi_q ? {1'b0, s5_ctx_q.a2, 32'd0} : 61'd0);
    s6_den = {s5_ctx_q.b2, 4'd0};
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      da_ctx_q[0] <= s5_ctx_q;
      da_rem_q[0] <= s6_num[60:29];
      da_nlo_q[0] <= s6_num[28:0];
      da_q_q[0]   <= '0;
      da_ovf_q[0] <= (s6_num[60:29] >= s6_den);
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar j = 0; j < NA; j++) begin : g_div_t
    logic [32:0] cat;
    logic [32:0] dv;
    logic        ge;

    always_comb begin
      cat = {da_rem_q[j], da_nlo_q[j][NA-1-j]};
      dv  = {1'b0, da_ctx_q[j].b2, 4'd0};
      ge  = (cat >= dv);
    end

    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        da_ctx_q[j+1] <= da_ctx_q[j];
        da_rem_q[j+1] <= ge ? 32'(cat - dv) : cat[31:0];
        da_nlo_q[j+1] <= da_nlo_q[j];
        da_q_q[j+1]   <= {da_q_q[j][27:0], ge};
        da_ovf_q[j+1] <= da_ovf_q[j];
      end
    end
  end

  // Stage 7: root argument and total reflection decision.
  rdu_pkg::rdu_ctx_t sq_ctx_q  [NS+1];
  logic [29:0]       sq_t_q    [NS+1];
  logic [32:0]       sq_rem_q  [NS+1];
  logic [28:0]       sq_root_q [NS+1];
  rdu_pkg::rdu_ctx_t s7_ctx;

  always_comb begin
    s7_ctx     = da_ctx_q[NA];
    s7_ctx.tir = da_ovf_q[NA] | (da_q_q[NA] > rdu_pkg::OneQ28);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      sq_ctx_q[0]  <= s7_ctx;
      sq_t_q[0]    <= {1'b0, rdu_pkg::OneQ28 - da_q_q[NA]};
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  // Digit-by-digit square root of t scaled by 2^28, one root bit per stage.
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int P = NS - 1 - k;
    logic [1:0]  pair;
    logic [32:0] cat;
    logic [32:0] trial;
    logic        ge;

    if (P >= 14) begin : g_pair_t
      assign pair = sq_t_q[k][2*P-27:2*P-28];
    end else begin : g_pair_zero
      assign pair = 2'b00;
    end

    always_comb begin
      cat   = {sq_rem_q[k][30:0], pair};
      trial = {2'b00, sq_root_q[k], 2'b01};
      ge    = (cat >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        sq_ctx_q[k+1]  <= sq_ctx_q[k];
        sq_t_q[k+1]    <= sq_t_q[k];
        sq_rem_q[k+1]  <= ge ? (cat - trial) : cat;
        sq_root_q[k+1] <= {sq_root_q[k][27:0], ge};
      end
    end
  end

  // Stage 8: partial terms of k = cos2*b - cmag*a and v*a.
  rdu_pkg::rdu_ctx_t  s8_ctx_q;
  logic [42:0]        s8_kp1_q;
  logic [42:0]        s8_kp2_q;
  logic signed [30:0] s8_vt_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s8_ctx_q <= sq_ctx_q[NS];
      s8_kp1_q <= 43'(sq_root_q[NS]) * 43'(sq_ctx_q[NS].b);
      s8_kp2_q <= 43'(sq_ctx_q[NS].cmag) * 43'(sq_ctx_q[NS].a);
      for (int i = 0; i < 3; i++) begin
        s8_vt_q[i] <= 31'($signed(sq_ctx_q[NS].v[i])) *
                      31'($signed({1'b0, sq_ctx_q[NS].a}));
      end
    end
  end

  // Stage 9: k.
  rdu_pkg::rdu_ctx_t  s9_ctx_q;
  logic signed [43:0] s9_k_q;
  logic signed [30:0] s9_vt_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s9_ctx_q <= s8_ctx_q;
      s9_k_q   <= $signed({1'b0, s8_kp1_q}) - $signed({1'b0, s8_kp2_q});
      s9_vt_q  <= s8_vt_q;
    end
  end

  // Stage 10: k times the oriented normal, split in two partial products.
  rdu_pkg::rdu_ctx_t  s10_ctx_q;
  logic signed [16:0] s10_np [3];
  logic signed [39:0] s10_pl_q [3];
  logic signed [38:0] s10_ph_q [3];
  logic signed [30:0] s10_vt_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s10_np[i] = s9_ctx_q.flip ? -17'($signed(s9_ctx_q.n0[i]))
                                :  17'($signed(s9_ctx_q.n0[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s10_ctx_q <= s9_ctx_q;
      s10_vt_q  <= s9_vt_q;
      for (int i = 0; i < 3; i++) begin
        s10_pl_q[i] <= 40'($signed({1'b0, s9_k_q[21:0]})) * 40'(s10_np[i]);
        s10_ph_q[i] <= 39'($signed(s9_k_q[43:22])) * 39'(s10_np[i]);
      end
    end
  end

  // Stage 11: direction numerators.
  rdu_pkg::rdu_ctx_t  s11_ctx_q;
  logic signed [61:0] s11_num_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s11_ctx_q <= s10_ctx_q;
      for (int i = 0; i < 3; i++) begin
        s11_num_q[i] <= -((62'(s10_vt_q[i]) <<< 28) + (62'(s10_ph_q[i]) <<< 22) +
                          62'(s10_pl_q[i]));
      end
    end
  end

  // Stage 12: magnitude, rounding offset and divider setup per lane.
  rdu_pkg::rdu_ctx_t db_ctx_q [NB+1];
  logic [13:0]       db_rem_q [NB+1][3];
  logic [16:0]       db_x_q   [NB+1][3];
  logic [16:0]       db_q_q   [NB+1][3];
  logic              db_ovf_q [NB+1][3];
  logic              db_neg_q [NB+1][3];
  logic [60:0]       s12_mag [3];
  logic [61:0]       s12_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s12_mag[i] = s11_num_q[i][61] ? 61'(-s11_num_q[i]) : 61'(s11_num_q[i]);
      s12_sum[i] = 62'(s12_mag[i]) + 62'({s11_ctx_q.b, 27'd0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      db_ctx_q[0] <= s11_ctx_q;
      for (int i = 0; i < 3; i++) begin
        db_rem_q[0][i] <= s12_sum[i][58:45];
        db_x_q[0][i]   <= s12_sum[i][44:28];
        db_q_q[0][i]   <= '0;
        db_ovf_q[0][i] <= (s12_sum[i][61:45] >= 17'(s11_ctx_q.b));
        db_neg_q[0][i] <= s11_num_q[i][61];
      end
    end
  end

  // Restoring divider by b, three lanes, one quotient bit per stage.
  for (genvar j = 0; j < NB; j++) begin : g_div_dir
    logic [14:0] cat [3];
    logic [14:0] bb;
    logic        ge  [3];

    always_comb begin
      bb = {1'b0, db_ctx_q[j].b};
      for (int i = 0; i < 3; i++) begin
        cat[i] = {db_rem_q[j][i], db_x_q[j][i][NB-1-j]};
        ge[i]  = (cat[i] >= bb);
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        db_ctx_q[j+1] <= db_ctx_q[j];
        for (int i = 0; i < 3; i++) begin
          db_rem_q[j+1][i] <= ge[i] ? 14'(cat[i] - bb) : cat[i][13:0];
          db_x_q[j+1][i]   <= db_x_q[j][i];
          db_q_q[j+1][i]   <= {db_q_q[j][i][15:0], ge[i]};
          db_ovf_q[j+1][i] <= db_ovf_q[j][i];
          db_neg_q[j+1][i] <= db_neg_q[j][i];
        end
      end
    end
  end

  // Stage 13: saturate and sign the direction components.
  rdu_pkg::rdu_ctx_t s13_ctx_q, s13_ctx;
  logic [15:0]       s13_qm [3];

  always_comb begin
    s13_ctx = db_ctx_q[NB];
    for (int i = 0; i < 3; i++) begin
      s13_qm[i] = (db_ovf_q[NB][i] || (db_q_q[NB][i] > 17'd32768)) ? 16'h8000
                                                                   : db_q_q[NB][i][15:0];
      if (db_neg_q[NB][i]) begin
        s13_ctx.w[i] = 16'(-s13_qm[i]);
      end else begin
        s13_ctx.w[i] = s13_qm[i][15] ? 16'h7FFF : s13_qm[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) s13_ctx_q <= s13_ctx;
  end

  // Stage 14: n0.w products and kt*a^2.
  rdu_pkg::rdu_ctx_t  s14_ctx_q;
  logic signed [31:0] s14_pw_q [3];
  logic [43:0]        s14_qw_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s14_ctx_q <= s13_ctx_q;
      s14_qw_q  <= 44'(trans_coeff_q) * 44'(s13_ctx_q.a2);
      for (int i = 0; i < 3; i++) begin
        s14_pw_q[i] <= $signed(s13_ctx_q.n0[i]) * $signed(s13_ctx_q.w[i]);
      end
    end
  end

  // Stage 15: |n0.w|.
  rdu_pkg::rdu_ctx_t  s15_ctx_q;
  logic [31:0]        s15_d_q;
  logic [43:0]        s15_qw_q;
  logic signed [33:0] s15_dot;

  assign s15_dot = 34'(s14_pw_q[0]) + 34'(s14_pw_q[1]) + 34'(s14_pw_q[2]);

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s15_ctx_q <= s14_ctx_q;
      s15_d_q   <= s15_dot[33] ? 32'(-s15_dot) : 32'(s15_dot);
      s15_qw_q  <= s14_qw_q;
    end
  end

  // Stage 16: weight divisor b^2*|n0.w|.
  rdu_pkg::rdu_ctx_t s16_ctx_q;
  logic [59:0]       s16_den_q;
  logic [43:0]       s16_qw_q;
  logic              s16_dz_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s16_ctx_q <= s15_ctx_q;
      s16_den_q <= 60'(s15_ctx_q.b2) * 60'(s15_d_q);
      s16_qw_q  <= s15_qw_q;
      s16_dz_q  <= (s15_d_q == '0);
    end
  end

  // Stage 17: weight saturation test and divider setup.
  rdu_pkg::rdu_ctx_t dc_ctx_q [NC+1];
  logic [59:0]       dc_rem_q [NC+1];
  logic [59:0]       dc_den_q [NC+1];
  logic [23:0]       dc_q_q   [NC+1];
  logic              dc_sat_q [NC+1];
  logic [59:0]       s17_rem;

  assign s17_rem = {11'd0, s16_qw_q, 5'd0};

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      dc_ctx_q[0] <= s16_ctx_q;
      dc_rem_q[0] <= s17_rem;
      dc_den_q[0] <= s16_den_q;
      dc_q_q[0]   <= '0;
      dc_sat_q[0] <= s16_dz_q | (s17_rem >= s16_den_q);
    end
  end

  // Restoring divider for the weight fraction, one bit per stage.
  for (genvar j = 0; j < NC; j++) begin : g_div_wt
    logic [60:0] cat;
    logic [60:0] dd;
    logic        ge;

    always_comb begin
      cat = {dc_rem_q[j], 1'b0};
      dd  = {1'b0, dc_den_q[j]};
      ge  = (cat >= dd);
    end

    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        dc_ctx_q[j+1] <= dc_ctx_q[j];
        dc_rem_q[j+1] <= ge ? 60'(cat - dd) : cat[59:0];
        dc_den_q[j+1] <= dc_den_q[j];
        dc_q_q[j+1]   <= {dc_q_q[j][22:0], ge};
        dc_sat_q[j+1] <= dc_sat_q[j];
      end
    end
  end

  // Output register; total reflection forces direction and weight to zero.
  logic [15:0] out_x_q, out_y_q, out_z_q;
  logic        out_tir_q;
  logic [23:0] out_wt_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      out_tir_q <= dc_ctx_q[NC].tir;
      out_x_q   <= dc_ctx_q[NC].tir ? 16'd0 : dc_ctx_q[NC].w[0];
      out_y_q   <= dc_ctx_q[NC].tir ? 16'd0 : dc_ctx_q[NC].w[1];
      out_z_q   <= dc_ctx_q[NC].tir ? 16'd0 : dc_ctx_q[NC].w[2];
      if (dc_ctx_q[NC].tir) begin
        out_wt_q <= '0;
      end else begin
        out_wt_q <= dc_sat_q[NC] ? rdu_pkg::WeightMax : dc_q_q[NC];
      end
    end
  end

  assign refr_x_o        = $signed(out_x_q);
  assign refr_y_o        = $signed(out_y_q);
  assign refr_z_o        = $signed(out_z_q);
  assign total_reflect_o = out_tir_q;
  assign weight_o        = out_wt_q;

  // Checks on the pipeline control and the reflection result.
  `RDU_ASSERT(a_tir_zero, out_valid_o && total_reflect_o, weight_o == '0 && refr_x_o == '0 && refr_y_o == '0 && refr_z_o == '0, "total reflection result not zero")
  `RDU_ASSERT(a_stall_only_full, in_stall_o, out_valid_o && out_stall_i, "input stalled while output free")
  `RDU_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0], "accepted request missing in first stage")
  `RDU_ASSERT_NEXT(a_valid_moves, !in_stall_o, vld_q[1] == $past(vld_q[0]), "valid bit lost between stages")

endmodule

`default_nettype wire
